>>> rtl/uxtc_pkg.sv
// Shared types, constants and tables for the Unix time / calendar converter.
// Used by uxtc_split, uxtc_pack and unix_time_calendar_converter_core.
package uxtc_pkg;

    localparam logic CMD_TO_CALENDAR = 1'b0;
    localparam logic CMD_TO_SECONDS  = 1'b1;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } cal_t;

    // Register stages in each conversion path before the output register.
    localparam int PIPE_DEPTH = 8;
    localparam int PACK_STAGES = 5;
    localparam int PACK_PAD = PIPE_DEPTH - PACK_STAGES;

    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int JDN_1970       = 2440588;
    localparam int JDN_MARCH_BASE = 1721119;
    localparam int DAYS_4Y        = 1461;
    localparam int DAYS_400Y      = 146097;
    localparam int DAYS_5MONTHS   = 153;
    localparam int YEAR_MIN       = 1970;
    localparam int YEAR_MAX       = 2069;
    localparam int FIRST_CENT     = 19;

    // Days from the March-based epoch of the day count to 1970-01-01.
    localparam int DAY_ZERO = JDN_1970 - JDN_MARCH_BASE;
    // Quarter-day count of 1970 onwards, taken relative to the first century.
    localparam int CENT_BIAS = 4 * DAY_ZERO - 1 - FIRST_CENT * DAYS_400Y;
    localparam int CENT_DAYS_LO = (FIRST_CENT * DAYS_400Y) >> 2;
    localparam int CENT_DAYS_HI = ((FIRST_CENT + 1) * DAYS_400Y) >> 2;
    localparam int CENT_SPLIT_YEAR = (FIRST_CENT + 1) * 100;

    // Exact reciprocals: for x below 2^N and 2^L not below the divisor,
    // ceil(2^(N+L) / d) gives floor(x / d) after a right shift by N + L.
    localparam int DAY_PRESHIFT = 7;
    localparam int DAY_ODD      = SECS_PER_DAY >> DAY_PRESHIFT;
    localparam int DAY_SHIFT    = 35;
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_SHIFT) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

    localparam int HOUR_SHIFT = 29;
    localparam logic [17:0] HOUR_RECIP =
        18'(((64'd1 << HOUR_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

    localparam int MIN_SHIFT = 18;
    localparam logic [12:0] MIN_RECIP =
        13'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

    localparam int YEAR_SHIFT = 29;
    localparam logic [18:0] YEAR_RECIP =
        19'(((64'd1 << YEAR_SHIFT) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    localparam int MON_SHIFT = 19;
    localparam logic [11:0] MON_RECIP =
        12'(((64'd1 << MON_SHIFT) + 64'(DAYS_5MONTHS) - 64'd1) / 64'(DAYS_5MONTHS));

    localparam int DAY5_SHIFT = 11;
    localparam logic [8:0] DAY5_RECIP = 9'(((64'd1 << DAY5_SHIFT) + 64'd4) / 64'd5);

    // Days before the start of each month of a year that begins in March.
    function automatic logic [8:0] month_days(input logic [3:0] mm);
        logic [8:0] d;
        unique case (mm)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/unix_time_calendar_converter_core.sv
// Top level of the Unix time / Gregorian calendar converter.
// Depends on uxtc_pkg, uxtc_split and uxtc_pack.
//
//  Channel  | Handshake            | Word
//  ---------+----------------------+-----------------------------------------------
//  command  | start, busy          | command, unix_seconds, second_in .. year_in
//  result   | done (strobe)        | seconds_out, second_out .. year_out, bad_field
//
// A word is taken on every clock edge with start high; busy is always low.
// Each result leaves one cycle wide on done, in command order, after the
// eight-stage split or pack pipeline and the output register. Reset clears
// the valid bits only; words in flight at reset are dropped. The receiver
// cannot stall the results.
module unix_time_calendar_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] unix_seconds,
    input  logic [5:0]  second_in,
    input  logic [5:0]  minute_in,
    input  logic [4:0]  hour_in,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [11:0] year_in,
    output logic        done,
    output logic [31:0] seconds_out,
    output logic [5:0]  second_out,
    output logic [5:0]  minute_out,
    output logic [4:0]  hour_out,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [11:0] year_out,
    output logic        bad_field
);

    localparam int DEPTH = uxtc_pkg::PIPE_DEPTH;

    logic                 accept;
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     cmd_reg;
    logic                 done_reg;
    uxtc_pkg::cal_t       in_cal;
    uxtc_pkg::cal_t       split_cal;
    logic [31:0]          split_secs;
    logic [31:0]          pack_secs;
    logic                 pack_ok;
    logic [31:0]          res_secs_next;
    uxtc_pkg::cal_t       res_cal_next;
    logic                 res_bad_next;
    logic [31:0]          res_secs_reg;
    uxtc_pkg::cal_t       res_cal_reg;
    logic                 res_bad_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_cal.second = second_in;
    assign in_cal.minute = minute_in;
    assign in_cal.hour   = hour_in;
    assign in_cal.day    = day_in;
    assign in_cal.month  = month_in;
    assign in_cal.year   = year_in;

    uxtc_split u_split (
        .clk          (clk),
        .unix_seconds (unix_seconds),
        .seconds      (split_secs),
        .cal          (split_cal)
    );

    uxtc_pack u_pack (
        .clk     (clk),
        .cal     (in_cal),
        .seconds (pack_secs),
        .ok      (pack_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[DEPTH-2:0], accept};
            done_reg <= vld_reg[DEPTH-1];
        end
    end

    always_comb
    begin
        if (cmd_reg[DEPTH-1] == uxtc_pkg::CMD_TO_SECONDS)
        begin
            res_secs_next = pack_ok ? pack_secs : '0;
            res_cal_next  = '0;
            res_bad_next  = !pack_ok;
        end
        else
        begin
            res_secs_next = split_secs;
            res_cal_next  = split_cal;
            res_bad_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= {cmd_reg[DEPTH-2:0], command};
        res_secs_reg <= res_secs_next;
        res_cal_reg  <= res_cal_next;
        res_bad_reg  <= res_bad_next;
    end

    assign done        = done_reg;
    assign seconds_out = res_secs_reg;
    assign second_out  = res_cal_reg.second;
    assign minute_out  = res_cal_reg.minute;
    assign hour_out    = res_cal_reg.hour;
    assign day_out     = res_cal_reg.day;
    assign month_out   = res_cal_reg.month;
    assign year_out    = res_cal_reg.year;
    assign bad_field   = res_bad_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(DEPTH+1) done)
        else $error("result word missing after a taken command word");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_field) |-> (seconds_out == 32'd0) && (second_out == 6'd0)
            && (minute_out == 6'd0) && (hour_out == 5'd0) && (day_out == 5'd0)
            && (month_out == 4'd0) && (year_out == 12'd0))
        else $error("rejected calendar word carries non-zero fields");

    a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (month_out != 4'd0)) |-> !bad_field && (month_out <= 4'd12)
            && (hour_out <= 5'd23) && (minute_out <= 6'd59) && (second_out <= 6'd59)
            && (day_out != 5'd0) && (year_out >= 12'(uxtc_pkg::YEAR_MIN)))
        else $error("calendar result out of range");

endmodule

>>> rtl/uxtc_split.sv
// Pipeline that splits Unix seconds into a Gregorian calendar time.
// Depends on uxtc_pkg; non-power-of-two constant divisions use reciprocals.
module uxtc_split (
    input  logic           clk,
    input  logic [31:0]    unix_seconds,
    output logic [31:0]    seconds,
    output uxtc_pkg::cal_t cal
);

    logic [50:0] day_prod;
    logic [15:0] s1_days_next;
    logic [31:0] s1_secs_reg;
    logic [15:0] s1_days_reg;

    logic [32:0] day_secs;
    logic [16:0] s2_tod_next;
    logic [18:0] s2_u_next;
    logic [31:0] s2_secs_reg;
    logic [16:0] s2_tod_reg;
    logic [18:0] s2_u_reg;

    logic        ge1;
    logic        ge2;
    logic [18:0] cent_sub;
    logic [18:0] cent_rem;
    logic [17:0] s3_in_cent_next;
    logic [1:0]  s3_k_next;
    logic [34:0] hour_prod;
    logic [4:0]  s3_hour_next;
    logic [31:0] s3_secs_reg;
    logic [16:0] s3_tod_reg;
    logic [17:0] s3_in_cent_reg;
    logic [1:0]  s3_k_reg;
    logic [4:0]  s3_hour_reg;

    logic [36:0] year_prod;
    logic [6:0]  s4_yr_next;
    logic [16:0] hour_secs;
    logic [11:0] s4_rem_next;
    logic [31:0] s4_secs_reg;
    logic [17:0] s4_in_cent_reg;
    logic [1:0]  s4_k_reg;
    logic [4:0]  s4_hour_reg;
    logic [6:0]  s4_yr_reg;
    logic [11:0] s4_rem_reg;

    logic [17:0] yr_days;
    logic [10:0] s5_r1_next;
    logic [24:0] min_prod;
    logic [5:0]  s5_minute_next;
    logic [31:0] s5_secs_reg;
    logic [1:0]  s5_k_reg;
    logic [4:0]  s5_hour_reg;
    logic [6:0]  s5_yr_reg;
    logic [11:0] s5_rem_reg;
    logic [10:0] s5_r1_reg;
    logic [5:0]  s5_minute_reg;

    logic [8:0]  quarter;
    logic [10:0] s6_m5_next;
    logic [11:0] min_secs;
    logic [5:0]  s6_sec_next;
    logic [31:0] s6_secs_reg;
    logic [1:0]  s6_k_reg;
    logic [4:0]  s6_hour_reg;
    logic [6:0]  s6_yr_reg;
    logic [5:0]  s6_minute_reg;
    logic [5:0]  s6_sec_reg;
    logic [10:0] s6_m5_reg;

    logic [22:0] mon_prod;
    logic [3:0]  s7_mon_next;
    logic [31:0] s7_secs_reg;
    logic [1:0]  s7_k_reg;
    logic [4:0]  s7_hour_reg;
    logic [6:0]  s7_yr_reg;
    logic [5:0]  s7_minute_reg;
    logic [5:0]  s7_sec_reg;
    logic [10:0] s7_m5_reg;
    logic [3:0]  s7_mon_reg;

    logic [10:0] mon_days;
    logic [7:0]  s8_v_next;
    logic [31:0] s8_secs_reg;
    logic [1:0]  s8_k_reg;
    logic [4:0]  s8_hour_reg;
    logic [6:0]  s8_yr_reg;
    logic [5:0]  s8_minute_reg;
    logic [5:0]  s8_sec_reg;
    logic [3:0]  s8_mon_reg;
    logic [7:0]  s8_v_reg;

    logic [16:0] day_out_prod;
    logic        late;
    logic [11:0] year_base;

    // Whole days: the low seven bits of 86400 are zero, so divide by 675.
    assign day_prod     = 51'(unix_seconds[31:uxtc_pkg::DAY_PRESHIFT])
                        * 51'(uxtc_pkg::DAY_RECIP);
    assign s1_days_next = 16'(day_prod >> uxtc_pkg::DAY_SHIFT);

    assign day_secs    = 33'(s1_days_reg) * 33'(uxtc_pkg::SECS_PER_DAY);
    assign s2_tod_next = s1_secs_reg[16:0] - day_secs[16:0];
    assign s2_u_next   = 19'({s1_days_reg, 2'b00}) + 19'(uxtc_pkg::CENT_BIAS);

    assign ge1 = (s2_u_reg >= 19'(uxtc_pkg::DAYS_400Y));
    assign ge2 = (s2_u_reg >= 19'(2 * uxtc_pkg::DAYS_400Y));

    always_comb
    begin
        priority if (ge2)
        begin
            cent_sub  = 19'(2 * uxtc_pkg::DAYS_400Y);
            s3_k_next = 2'd2;
        end
        else if (ge1)
        begin
            cent_sub  = 19'(uxtc_pkg::DAYS_400Y);
            s3_k_next = 2'd1;
        end
        else
        begin
            cent_sub  = '0;
            s3_k_next = 2'd0;
        end
    end

    assign cent_rem        = s2_u_reg - cent_sub;
    assign s3_in_cent_next = cent_rem[17:0] | 18'd3;
    assign hour_prod       = 35'(s2_tod_reg) * 35'(uxtc_pkg::HOUR_RECIP);
    assign s3_hour_next    = 5'(hour_prod >> uxtc_pkg::HOUR_SHIFT);

    assign year_prod   = 37'(s3_in_cent_reg) * 37'(uxtc_pkg::YEAR_RECIP);
    assign s4_yr_next  = 7'(year_prod >> uxtc_pkg::YEAR_SHIFT);
    assign hour_secs   = 17'(s3_hour_reg) * 17'(uxtc_pkg::SECS_PER_HOUR);
    assign s4_rem_next = 12'(s3_tod_reg - hour_secs);

    assign yr_days        = 18'(s4_yr_reg) * 18'(uxtc_pkg::DAYS_4Y);
    assign s5_r1_next     = 11'(s4_in_cent_reg - yr_days);
    assign min_prod       = 25'(s4_rem_reg) * 25'(uxtc_pkg::MIN_RECIP);
    assign s5_minute_next = 6'(min_prod >> uxtc_pkg::MIN_SHIFT);

    assign quarter     = 9'((12'(s5_r1_reg) + 12'd4) >> 2);
    assign s6_m5_next  = 11'({quarter, 2'b00}) + 11'(quarter) - 11'd3;
    assign min_secs    = 12'(s5_minute_reg) * 12'(uxtc_pkg::SECS_PER_MIN);
    assign s6_sec_next = 6'(s5_rem_reg - min_secs);

    assign mon_prod    = 23'(s6_m5_reg) * 23'(uxtc_pkg::MON_RECIP);
    assign s7_mon_next = 4'(mon_prod >> uxtc_pkg::MON_SHIFT);

    assign mon_days  = 11'(s7_mon_reg) * 11'(uxtc_pkg::DAYS_5MONTHS);
    assign s8_v_next = 8'(s7_m5_reg - mon_days) + 8'd5;

    always_ff @(posedge clk)
    begin
        s1_secs_reg    <= unix_seconds;
        s1_days_reg    <= s1_days_next;

        s2_secs_reg    <= s1_secs_reg;
        s2_tod_reg     <= s2_tod_next;
        s2_u_reg       <= s2_u_next;

        s3_secs_reg    <= s2_secs_reg;
        s3_tod_reg     <= s2_tod_reg;
        s3_in_cent_reg <= s3_in_cent_next;
        s3_k_reg       <= s3_k_next;
        s3_hour_reg    <= s3_hour_next;

        s4_secs_reg    <= s3_secs_reg;
        s4_in_cent_reg <= s3_in_cent_reg;
        s4_k_reg       <= s3_k_reg;
        s4_hour_reg    <= s3_hour_reg;
        s4_yr_reg      <= s4_yr_next;
        s4_rem_reg     <= s4_rem_next;

        s5_secs_reg    <= s4_secs_reg;
        s5_k_reg       <= s4_k_reg;
        s5_hour_reg    <= s4_hour_reg;
        s5_yr_reg      <= s4_yr_reg;
        s5_rem_reg     <= s4_rem_reg;
        s5_r1_reg      <= s5_r1_next;
        s5_minute_reg  <= s5_minute_next;

        s6_secs_reg    <= s5_secs_reg;
        s6_k_reg       <= s5_k_reg;
        s6_hour_reg    <= s5_hour_reg;
        s6_yr_reg      <= s5_yr_reg;
        s6_minute_reg  <= s5_minute_reg;
        s6_sec_reg     <= s6_sec_next;
        s6_m5_reg      <= s6_m5_next;

        s7_secs_reg    <= s6_secs_reg;
        s7_k_reg       <= s6_k_reg;
        s7_hour_reg    <= s6_hour_reg;
        s7_yr_reg      <= s6_yr_reg;
        s7_minute_reg  <= s6_minute_reg;
        s7_sec_reg     <= s6_sec_reg;
        s7_m5_reg      <= s6_m5_reg;
        s7_mon_reg     <= s7_mon_next;

        s8_secs_reg    <= s7_secs_reg;
        s8_k_reg       <= s7_k_reg;
        s8_hour_reg    <= s7_hour_reg;
        s8_yr_reg      <= s7_yr_reg;
        s8_minute_reg  <= s7_minute_reg;
        s8_sec_reg     <= s7_sec_reg;
        s8_mon_reg     <= s7_mon_reg;
        s8_v_reg       <= s8_v_next;
    end

    // January and February close the March-based year and belong to the next one.
    assign late         = (s8_mon_reg >= 4'd10);
    assign day_out_prod = 17'(s8_v_reg) * 17'(uxtc_pkg::DAY5_RECIP);

    always_comb
    begin
        unique case (s8_k_reg)
            2'd0:    year_base = 12'(uxtc_pkg::FIRST_CENT * 100);
            2'd1:    year_base = 12'((uxtc_pkg::FIRST_CENT + 1) * 100);
            default: year_base = 12'((uxtc_pkg::FIRST_CENT + 2) * 100);
        endcase
    end

    assign seconds    = s8_secs_reg;
    assign cal.second = s8_sec_reg;
    assign cal.minute = s8_minute_reg;
    assign cal.hour   = s8_hour_reg;
    assign cal.day    = 5'(day_out_prod >> uxtc_pkg::DAY5_SHIFT);
    assign cal.month  = late ? (s8_mon_reg - 4'd9) : (s8_mon_reg + 4'd3);
    assign cal.year   = year_base + 12'(s8_yr_reg) + 12'(late);

endmodule

>>> rtl/uxtc_pack.sv
// Pipeline that checks calendar fields and packs them into Unix seconds.
// Depends on uxtc_pkg for the month table, constants and the calendar type.
module uxtc_pack (
    input  logic           clk,
    input  uxtc_pkg::cal_t cal,
    output logic [31:0]    seconds,
    output logic           ok
);

    logic        p1_ok_next;
    logic        early;
    logic [11:0] ym;
    logic [3:0]  mm;
    logic        p1_hi_next;
    logic [6:0]  p1_yy_next;
    logic        p1_ok_reg;
    logic [8:0]  p1_mdays_reg;
    logic [4:0]  p1_day_reg;
    logic        p1_hi_reg;
    logic [6:0]  p1_yy_reg;
    logic [4:0]  p1_hour_reg;
    logic [5:0]  p1_min_reg;
    logic [5:0]  p1_sec_reg;

    logic [17:0] yy_prod;
    logic        p2_ok_reg;
    logic [8:0]  p2_mdays_reg;
    logic [4:0]  p2_day_reg;
    logic        p2_hi_reg;
    logic [15:0] p2_yydays_reg;
    logic [16:0] p2_hsec_reg;
    logic [11:0] p2_msec_reg;
    logic [5:0]  p2_sec_reg;

    logic [20:0] day_sum;
    logic        p3_ok_reg;
    logic [15:0] p3_dnum_reg;
    logic [16:0] p3_tod_reg;

    logic [32:0] day_secs;
    logic        p4_ok_reg;
    logic [31:0] p4_prod_reg;
    logic [16:0] p4_tod_reg;

    logic        p5_ok_reg;
    logic [31:0] p5_secs_reg;

    logic [31:0] pad_secs_reg [uxtc_pkg::PACK_PAD];
    logic        pad_ok_reg   [uxtc_pkg::PACK_PAD];

    assign p1_ok_next = (cal.second <= 6'd59) && (cal.minute <= 6'd59)
                     && (cal.hour <= 5'd23) && (cal.day != 5'd0)
                     && (cal.month != 4'd0) && (cal.month <= 4'd12)
                     && (cal.year >= 12'(uxtc_pkg::YEAR_MIN))
                     && (cal.year <= 12'(uxtc_pkg::YEAR_MAX));

    // The year is counted from March, so January and February join the year before.
    assign early      = (cal.month <= 4'd2);
    assign ym         = early ? (cal.year - 12'd1) : cal.year;
    assign mm         = early ? (cal.month + 4'd9) : (cal.month - 4'd3);
    assign p1_hi_next = (ym >= 12'(uxtc_pkg::CENT_SPLIT_YEAR));
    assign p1_yy_next = p1_hi_next ? 7'(ym - 12'(uxtc_pkg::CENT_SPLIT_YEAR))
                                   : 7'(ym - 12'(uxtc_pkg::CENT_SPLIT_YEAR - 100));

    assign yy_prod = 18'(p1_yy_reg) * 18'(uxtc_pkg::DAYS_4Y);

    assign day_sum = 21'(p2_mdays_reg) + 21'(p2_day_reg) + 21'(p2_yydays_reg)
                   + (p2_hi_reg ? 21'(uxtc_pkg::CENT_DAYS_HI) : 21'(uxtc_pkg::CENT_DAYS_LO))
                   - 21'(uxtc_pkg::DAY_ZERO);

    assign day_secs = 33'(p3_dnum_reg) * 33'(uxtc_pkg::SECS_PER_DAY);

    always_ff @(posedge clk)
    begin
        p1_ok_reg     <= p1_ok_next;
        p1_mdays_reg  <= uxtc_pkg::month_days(mm);
        p1_day_reg    <= cal.day;
        p1_hi_reg     <= p1_hi_next;
        p1_yy_reg     <= p1_yy_next;
        p1_hour_reg   <= cal.hour;
        p1_min_reg    <= cal.minute;
        p1_sec_reg    <= cal.second;

        p2_ok_reg     <= p1_ok_reg;
        p2_mdays_reg  <= p1_mdays_reg;
        p2_day_reg    <= p1_day_reg;
        p2_hi_reg     <= p1_hi_reg;
        p2_yydays_reg <= 16'(yy_prod >> 2);
        p2_hsec_reg   <= 17'(p1_hour_reg) * 17'(uxtc_pkg::SECS_PER_HOUR);
        p2_msec_reg   <= 12'(p1_min_reg) * 12'(uxtc_pkg::SECS_PER_MIN);
        p2_sec_reg    <= p1_sec_reg;

        p3_ok_reg     <= p2_ok_reg;
        p3_dnum_reg   <= day_sum[15:0];
        p3_tod_reg    <= p2_hsec_reg + 17'(p2_msec_reg) + 17'(p2_sec_reg);

        p4_ok_reg     <= p3_ok_reg;
        p4_prod_reg   <= day_secs[31:0];
        p4_tod_reg    <= p3_tod_reg;

        p5_ok_reg     <= p4_ok_reg;
        p5_secs_reg   <= p4_prod_reg + 32'(p4_tod_reg);

        pad_secs_reg[0] <= p5_secs_reg;
        pad_ok_reg[0]   <= p5_ok_reg;
        for (int i = 1; i < uxtc_pkg::PACK_PAD; i++)
        begin
            pad_secs_reg[i] <= pad_secs_reg[i-1];
            pad_ok_reg[i]   <= pad_ok_reg[i-1];
        end
    end

    assign seconds = pad_secs_reg[uxtc_pkg::PACK_PAD-1];
    assign ok      = pad_ok_reg[uxtc_pkg::PACK_PAD-1];

endmodule
